/* hdl/rlp_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// rlp_pkg
// Shared types and codes of the RLP stream decoder: result kinds, parser
// phases, field widths and the result beat that travels to the output stage.
// ============================================================================
package rlp_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned KIND_W        = 3;
    localparam int unsigned ITEM_LEN_W    = 64;
    localparam int unsigned LEN_BITS_DFLT = 64;
    localparam int unsigned LEN_CNT_W     = 4;
    localparam int unsigned PHASE_W       = 2;

    localparam logic [KIND_W-1:0] K_SINGLE  = 3'd0;
    localparam logic [KIND_W-1:0] K_STRHDR  = 3'd1;
    localparam logic [KIND_W-1:0] K_LISTHDR = 3'd2;
    localparam logic [KIND_W-1:0] K_PAYLOAD = 3'd3;
    localparam logic [KIND_W-1:0] K_TRUNC   = 3'd4;

    localparam logic [PHASE_W-1:0] PH_PREFIX   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_LENBYTES = 2'd1;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD  = 2'd2;

    localparam logic [BYTE_W-1:0] SINGLE_MAX    = 8'h7f;
    localparam logic [BYTE_W-1:0] STR_BASE      = 8'h80;
    localparam logic [BYTE_W-1:0] STR_SHORT_MAX = 8'hb7;
    localparam logic [BYTE_W-1:0] STR_LONG_MAX  = 8'hbf;
    localparam logic [BYTE_W-1:0] LIST_BASE     = 8'hc0;
    localparam logic [BYTE_W-1:0] LIST_SHORT_MAX = 8'hf7;

    typedef struct packed {
        logic                  vld;
        logic [KIND_W-1:0]     kind;
        logic [ITEM_LEN_W-1:0] item_length;
        logic [BYTE_W-1:0]     out_byte;
        logic                  end_of_item;
    } t_result;

endpackage

/* hdl/rlp_in_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// rlp_in_if
// Input channel of the decoder: one encoded byte per beat.
// ============================================================================
interface rlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

/* hdl/rlp_out_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// rlp_out_if
// Output channel of the decoder: one header, payload byte or error per beat.
// ============================================================================
interface rlp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] item_length;
    logic [7:0]  out_byte;
    logic        end_of_item;

    modport source (output valid, output kind, output item_length, output out_byte,
                    output end_of_item, input ready);
    modport sink   (input valid, input kind, input item_length, input out_byte,
                    input end_of_item, output ready);
endinterface

/* hdl/rlp_stream_decoder.sv */
`timescale 1ns / 1ps
// ============================================================================
// rlp_stream_decoder
// Byte-serial RLP decoder: reports single-byte strings, string and list headers
// with their payload length, passes string payload bytes through and flags truncation.
// ============================================================================
//  Channel   Dir  Beat contents
//  i_in      in   data_byte, end_of_input
//  o_out     out  kind, item_length, out_byte, end_of_item
//
//  One input byte is accepted per cycle while i_in is ready; its result, if any,
//  appears on o_out in the cycle after, out of the result register.
//  The parser state and the result register update in the same cycle, so
//  the rate is set by the single classify-and-count step per byte.
//  i_rst_n is synchronous and active low; after it the parser expects a
//  prefix and no result is pending.
//  A stalled o_out holds its beat; i_in stays ready while the result
//  register is empty or is being taken in the same cycle.
// ============================================================================
module rlp_stream_decoder
    import rlp_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LEN_BITS_DFLT
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rlp_in_if.sink   i_in,
    rlp_out_if.source o_out
);

    logic    take;
    logic    in_ready;
    logic    out_vld;
    t_result res;
    t_result out_data;

    assign take       = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    rlp_parse #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_data_byte    (i_in.data_byte),
        .i_end_of_input (i_in.end_of_input),
        .o_res          (res)
    );

    rlp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_valid     (out_vld),
        .o_data      (out_data)
    );

    assign o_out.valid       = out_vld;
    assign o_out.kind        = out_data.kind;
    assign o_out.item_length = out_data.item_length;
    assign o_out.out_byte    = out_data.out_byte;
    assign o_out.end_of_item = out_data.end_of_item;

endmodule

/* hdl/rlp_parse.sv */
`timescale 1ns / 1ps
// ============================================================================
// rlp_parse
// Prefix classifier and parser state: gathers long-form lengths, counts down
// string payloads and forms at most one result for each accepted byte.
// ============================================================================
module rlp_parse
    import rlp_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LEN_BITS_DFLT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_end_of_input,
    output t_result           o_res
);

    logic [PHASE_W-1:0]     r_phase,   n_phase;
    logic [LEN_CNT_W-1:0]   r_left,    n_left;
    logic [LENGTH_BITS-1:0] r_acc,     n_acc;
    logic                   r_is_list, n_is_list;
    logic [LENGTH_BITS-1:0] r_pay,     n_pay;

    logic [LENGTH_BITS-1:0] acc_next;
    logic [LENGTH_BITS-1:0] pay_dec;
    logic [LENGTH_BITS-1:0] short_len;
    logic [LEN_CNT_W-1:0]   left_dec;
    logic [BYTE_W-1:0]      str_diff;
    logic [BYTE_W-1:0]      list_diff;
    logic                   open_list;
    t_result                res;

    assign str_diff  = i_data_byte - STR_BASE;
    assign list_diff = i_data_byte - LIST_BASE;
    assign left_dec  = r_left - LEN_CNT_W'(1);
    assign pay_dec   = r_pay - LENGTH_BITS'(1);

    always_comb begin
        if (r_acc[LENGTH_BITS-1 -: BYTE_W] != '0) begin
            acc_next = '1;
        end else begin
            acc_next = (r_acc << BYTE_W) | LENGTH_BITS'(i_data_byte);
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_left    = r_left;
        n_acc     = r_acc;
        n_is_list = r_is_list;
        n_pay     = r_pay;
        open_list = 1'b0;
        short_len = '0;
        res       = '0;

        unique case (r_phase)
            PH_LENBYTES: begin
                n_acc  = acc_next;
                n_left = left_dec;
                if (left_dec == '0) begin
                    res.vld         = 1'b1;
                    res.kind        = r_is_list ? K_LISTHDR : K_STRHDR;
                    res.item_length = ITEM_LEN_W'(acc_next);
                    res.end_of_item = (acc_next == '0);
                    n_phase         = PH_PREFIX;
                    if (r_is_list) begin
                        open_list = (acc_next != '0);
                    end else if (acc_next != '0) begin
                        n_pay   = acc_next;
                        n_phase = PH_PAYLOAD;
                    end
                    n_is_list = 1'b0;
                    n_acc     = '0;
                end
            end
            PH_PAYLOAD: begin
                n_pay           = pay_dec;
                res.vld         = 1'b1;
                res.kind        = K_PAYLOAD;
                res.out_byte    = i_data_byte;
                res.end_of_item = (pay_dec == '0);
                if (pay_dec == '0) begin
                    n_phase = PH_PREFIX;
                end
            end
            default: begin
                n_phase = PH_PREFIX;
                priority if (i_data_byte <= SINGLE_MAX) begin
                    res.vld         = 1'b1;
                    res.kind        = K_SINGLE;
                    res.item_length = ITEM_LEN_W'(1);
                    res.out_byte    = i_data_byte;
                    res.end_of_item = 1'b1;
                end else if (i_data_byte <= STR_SHORT_MAX) begin
                    short_len       = LENGTH_BITS'(str_diff);
                    res.vld         = 1'b1;
                    res.kind        = K_STRHDR;
                    res.item_length = ITEM_LEN_W'(short_len);
                    res.end_of_item = (short_len == '0);
                    if (short_len != '0) begin
                        n_pay   = short_len;
                        n_phase = PH_PAYLOAD;
                    end
                end else if (i_data_byte <= STR_LONG_MAX) begin
                    n_left    = LEN_CNT_W'(i_data_byte - STR_SHORT_MAX);
                    n_acc     = '0;
                    n_is_list = 1'b0;
                    n_phase   = PH_LENBYTES;
                end else if (i_data_byte <= LIST_SHORT_MAX) begin
                    short_len       = LENGTH_BITS'(list_diff);
                    res.vld         = 1'b1;
                    res.kind        = K_LISTHDR;
                    res.item_length = ITEM_LEN_W'(short_len);
                    res.end_of_item = (short_len == '0);
                    open_list       = (short_len != '0);
                end else begin
                    n_left    = LEN_CNT_W'(i_data_byte - LIST_SHORT_MAX);
                    n_acc     = '0;
                    n_is_list = 1'b1;
                    n_phase   = PH_LENBYTES;
                end
            end
        endcase

        if (i_end_of_input) begin
            if (n_phase != PH_PREFIX || open_list) begin
                res      = '0;
                res.vld  = 1'b1;
                res.kind = K_TRUNC;
            end
            n_phase   = PH_PREFIX;
            n_left    = '0;
            n_acc     = '0;
            n_is_list = 1'b0;
            n_pay     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_PREFIX;
            r_left    <= '0;
            r_acc     <= '0;
            r_is_list <= 1'b0;
            r_pay     <= '0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_left    <= n_left;
            r_acc     <= n_acc;
            r_is_list <= n_is_list;
            r_pay     <= n_pay;
        end
    end

    always_comb begin
        o_res     = res;
        o_res.vld = res.vld & i_take;
    end

endmodule

/* hdl/rlp_out_stage.sv */
`timescale 1ns / 1ps
// ============================================================================
// rlp_out_stage
// Result register between the parser and the output channel. It refills in
// the same cycle in which its beat is taken.
// ============================================================================
module rlp_out_stage
    import rlp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_res,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_valid,
    output t_result o_data
);

    logic    r_vld;
    t_result r_data;

    assign o_in_ready = !r_vld || i_out_ready;
    assign o_valid    = r_vld;
    assign o_data     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_res.vld) begin
            r_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.vld) begin
            r_data <= i_res;
        end
    end

endmodule

/* hdl/rlp_chk.sv */
`timescale 1ns / 1ps
// ============================================================================
// rlp_chk
// Port-level checks of the decoder, attached to the top level by a bind.
// ============================================================================
module rlp_chk
    import rlp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [KIND_W-1:0]     i_kind,
    input logic [ITEM_LEN_W-1:0] i_item_length,
    input logic [BYTE_W-1:0]     i_out_byte,
    input logic                  i_end_of_item
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_item_length) && $stable(i_out_byte) && $stable(i_end_of_item))
        else $error("Output beat changed while stalled.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("Input not ready although the result register is free.");

    a_trunc_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == K_TRUNC |->
            i_item_length == '0 && i_out_byte == '0 && !i_end_of_item)
        else $error("Truncation beat carries data.");

    a_single_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == K_SINGLE |->
            i_item_length == ITEM_LEN_W'(1) && i_end_of_item && i_out_byte <= SINGLE_MAX)
        else $error("Malformed single-byte string beat.");

    a_header_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == K_STRHDR || i_kind == K_LISTHDR) |->
            i_out_byte == '0 && i_end_of_item == (i_item_length == '0))
        else $error("Malformed header beat.");

endmodule

bind rlp_stream_decoder rlp_chk u_rlp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_kind        (o_out.kind),
    .i_item_length (o_out.item_length),
    .i_out_byte    (o_out.out_byte),
    .i_end_of_item (o_out.end_of_item)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the byte-serial RLP stream decoder. Encoded bytes
// go in through a bursty sender and results are drained by a receiver that
// stalls on its own pattern. A cycle-free decoder model in the bench predicts
// each result, and every result beat is checked in order against it. Directed
// streams cover the prefix classes, long forms and truncation. Random
// well-formed streams, cut streams and raw noise follow.
// ============================================================================
module tb_top;
    import rlp_pkg::*;

    localparam int unsigned LEN_BITS  = LEN_BITS_DFLT;
    localparam logic [63:0] LEN_MASK  = {64{1'b1}} >> (64 - LEN_BITS);
    localparam int          RAND_BEATS  = 1150;
    localparam int          TOTAL_BEATS = 1400;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [ITEM_LEN_W-1:0] item_length;
        logic [BYTE_W-1:0]     out_byte;
        logic                  end_of_item;
    } rlp_beat_t;

    logic i_clk;
    logic i_rst_n;

    rlp_in_if  in_if ();
    rlp_out_if out_if ();

    rlp_stream_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [PHASE_W-1:0]   dec_phase;
    logic [LEN_CNT_W-1:0] dec_len_bytes;
    logic [63:0]          dec_len_acc;
    logic                 dec_is_list;
    logic [63:0]          dec_payload_left;

    rlp_beat_t   pending_results[$];
    logic [7:0]  stream_bytes[$];
    int          burst_left;
    int          n_beats_sent;
    int          n_results_seen;
    int          n_trunc_seen;
    int          n_errors;
    int          n_shown;
    logic [31:0] rx_cyc;
    rlp_beat_t   rx_got;
    rlp_beat_t   rx_want;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("tb_top: timed out with %0d results outstanding", pending_results.size());
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic rlp_beat_t make_beat(input logic [KIND_W-1:0] kind,
                                            input logic [63:0] len,
                                            input logic [7:0] ob,
                                            input logic eoi);
        rlp_beat_t r;
        r.kind        = kind;
        r.item_length = len;
        r.out_byte    = ob;
        r.end_of_item = eoi;
        return r;
    endfunction

    function automatic void clear_decoder();
        dec_phase        = PH_PREFIX;
        dec_len_bytes    = '0;
        dec_len_acc      = '0;
        dec_is_list      = 1'b0;
        dec_payload_left = '0;
    endfunction

    // Decodes one byte; returns 1 when the byte yields a result beat.
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output rlp_beat_t r);
        bit          hit;
        bit          open_list;
        logic [63:0] len;
        hit       = 1'b0;
        open_list = 1'b0;
        r         = '0;
        case (dec_phase)
            PH_LENBYTES: begin
                if ((dec_len_acc >> (LEN_BITS - 8)) != 0)
                    dec_len_acc = LEN_MASK;
                else
                    dec_len_acc = ((dec_len_acc << 8) | 64'(b)) & LEN_MASK;
                dec_len_bytes = dec_len_bytes - 1'b1;
                if (dec_len_bytes == 0) begin
                    len = dec_len_acc;
                    r   = make_beat(dec_is_list ? K_LISTHDR : K_STRHDR, len, 8'h00, len == 0);
                    hit = 1'b1;
                    if (dec_is_list) begin
                        open_list = (len != 0);
                        dec_phase = PH_PREFIX;
                    end else if (len != 0) begin
                        dec_payload_left = len;
                        dec_phase        = PH_PAYLOAD;
                    end else begin
                        dec_phase = PH_PREFIX;
                    end
                    dec_is_list = 1'b0;
                    dec_len_acc = '0;
                end
            end
            PH_PAYLOAD: begin
                dec_payload_left = dec_payload_left - 1;
                r   = make_beat(K_PAYLOAD, 64'd0, b, dec_payload_left == 0);
                hit = 1'b1;
                if (dec_payload_left == 0)
                    dec_phase = PH_PREFIX;
            end
            default: begin
                dec_phase = PH_PREFIX;
                if (b <= SINGLE_MAX) begin
                    r   = make_beat(K_SINGLE, 64'd1, b, 1'b1);
                    hit = 1'b1;
                end else if (b <= STR_SHORT_MAX) begin
                    len = 64'(b - STR_BASE);
                    r   = make_beat(K_STRHDR, len, 8'h00, len == 0);
                    hit = 1'b1;
                    if (len != 0) begin
                        dec_payload_left = len;
                        dec_phase        = PH_PAYLOAD;
                    end
                end else if (b <= STR_LONG_MAX) begin
                    dec_len_bytes = LEN_CNT_W'(b - STR_SHORT_MAX);
                    dec_len_acc   = '0;
                    dec_is_list   = 1'b0;
                    dec_phase     = PH_LENBYTES;
                end else if (b <= LIST_SHORT_MAX) begin
                    len       = 64'(b - LIST_BASE);
                    r         = make_beat(K_LISTHDR, len, 8'h00, len == 0);
                    hit       = 1'b1;
                    open_list = (len != 0);
                end else begin
                    dec_len_bytes = LEN_CNT_W'(b - LIST_SHORT_MAX);
                    dec_len_acc   = '0;
                    dec_is_list   = 1'b1;
                    dec_phase     = PH_LENBYTES;
                end
            end
        endcase
        if (last) begin
            if (dec_phase != PH_PREFIX || open_list) begin
                r   = make_beat(K_TRUNC, 64'd0, 8'h00, 1'b0);
                hit = 1'b1;
            end
            clear_decoder();
        end
        return hit;
    endfunction

    // Sends one beat, opening a random gap, which may be empty, whenever the current burst runs out.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int        gap;
        rlp_beat_t r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        in_if.valid        <= 1'b1;
        in_if.data_byte    <= b;
        in_if.end_of_input <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        burst_left--;
        n_beats_sent++;
        if (decode_byte(b, last, r))
            pending_results.push_back(r);
    endtask

    task automatic send_stream(input logic [7:0] bytes[$]);
        foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    task automatic push_length(input logic [63:0] len, input int nbytes);
        for (int k = nbytes - 1; k >= 0; k--) stream_bytes.push_back(8'(len >> (8 * k)));
    endtask

    // Appends one random, well-formed item to the stream under construction.
    task automatic push_item();
        int          sel;
        int          nlen;
        logic [63:0] len;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            stream_bytes.push_back(8'($urandom_range(0, 127)));
        end else if (sel < 5 || sel == 9) begin
            len = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 6) : $urandom_range(7, 55);
            stream_bytes.push_back(STR_BASE + 8'(len));
            repeat (int'(len)) stream_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (sel == 5) begin
            nlen = $urandom_range(1, 8);
            len  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 20) : $urandom_range(56, 70);
            stream_bytes.push_back(STR_SHORT_MAX + 8'(nlen));
            push_length(len, nlen);
            repeat (int'(len)) stream_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (sel < 8) begin
            stream_bytes.push_back(LIST_BASE + 8'($urandom_range(0, 55)));
        end else begin
            nlen = $urandom_range(1, 8);
            len  = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : $urandom_range(0, 300);
            stream_bytes.push_back(LIST_SHORT_MAX + 8'(nlen));
            push_length(len, nlen);
        end
    endtask

    task automatic test_short_forms();
        send_stream('{8'h00, 8'h7f});
        send_stream('{8'h80});
        send_stream('{8'h82, 8'hff, 8'h00});
        send_stream('{8'hc0, 8'hc1, 8'h05});
        send_stream('{8'h81, 8'h01});
    endtask

    task automatic test_long_forms();
        send_stream('{8'hb8, 8'h00});
        send_stream('{8'hf8, 8'h01, 8'h7f});
        send_stream('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00});
    endtask

    task automatic test_truncation();
        send_stream('{8'h85, 8'h01});
        send_stream('{8'hc3});
        send_stream('{8'hb9, 8'h00});
    endtask

    task automatic test_random_streams();
        int cut;
        while (n_beats_sent < RAND_BEATS) begin
            stream_bytes.delete();
            repeat ($urandom_range(1, 6)) push_item();
            cut = stream_bytes.size() - 1;
            if ($urandom_range(0, 4) == 0)
                cut = $urandom_range(0, stream_bytes.size() - 1);
            for (int i = 0; i <= cut; i++) send_byte(stream_bytes[i], i == cut);
        end
    endtask

    task automatic test_random_noise();
        while (n_beats_sent < TOTAL_BEATS)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    endtask

    task automatic flag_mismatch(input string what, input rlp_beat_t want, input rlp_beat_t got);
        n_errors++;
        if (n_shown < 10) begin
            n_shown++;
            $display("tb_top: %s at %0t: want kind %0d len %0h byte %02h eoi %0b, got kind %0d len %0h byte %02h eoi %0b",
                     what, $realtime, want.kind, want.item_length, want.out_byte,
                     want.end_of_item, got.kind, got.item_length, got.out_byte,
                     got.end_of_item);
        end
    endtask

    initial out_if.ready = 1'b0;
    initial rx_cyc = '0;

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            rx_got.kind        = out_if.kind;
            rx_got.item_length = out_if.item_length;
            rx_got.out_byte    = out_if.out_byte;
            rx_got.end_of_item = out_if.end_of_item;
            n_results_seen++;
            if (rx_got.kind == K_TRUNC)
                n_trunc_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected beat", '0, rx_got);
            end else begin
                rx_want = pending_results.pop_front();
                if (rx_got.kind !== rx_want.kind || rx_got.item_length !== rx_want.item_length
                    || rx_got.out_byte !== rx_want.out_byte
                    || rx_got.end_of_item !== rx_want.end_of_item)
                    flag_mismatch("mismatch", rx_want, rx_got);
            end
        end
        rx_cyc <= rx_cyc + 1;
        case (rx_cyc[8:7])
            2'd0:    out_if.ready <= 1'b1;
            2'd1:    out_if.ready <= 1'($urandom_range(0, 1));
            2'd2:    out_if.ready <= (rx_cyc[1:0] != 2'd0);
            default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    initial begin
        in_if.valid        <= 1'b0;
        in_if.data_byte    <= 8'h00;
        in_if.end_of_input <= 1'b0;
        i_rst_n            <= 1'b0;
        burst_left     = 0;
        n_beats_sent   = 0;
        n_results_seen = 0;
        n_trunc_seen   = 0;
        n_errors       = 0;
        n_shown        = 0;
        clear_decoder();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_forms();
        test_long_forms();
        test_truncation();
        test_random_streams();
        test_random_noise();

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("tb_top: %0d encoded bytes sent, %0d result beats checked, %0d truncations",
                 n_beats_sent, n_results_seen, n_trunc_seen);
        $display("tb_top: %0d mismatching beats", n_errors);
        if (n_errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
